FILE: rtl/ttyld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ttyld_pkg;

    localparam int LINE_DEPTH_DEF = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_MAP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_CRLF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_CHARS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EDIT_CHARS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HANDLER     = 3'd5;

    localparam logic [2:0]  RST_INPUT_MAP    = 3'd2;
    localparam logic [5:0]  RST_LOCAL_MODE   = 6'd31;
    localparam logic        RST_ECHO_CRLF    = 1'b1;
    localparam logic [23:0] RST_SIGNAL_CHARS = {8'd26, 8'd28, 8'd3};
    localparam logic [23:0] RST_EDIT_CHARS   = {8'd4, 8'd21, 8'd127};
    localparam logic        RST_HANDLER      = 1'b0;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_ECHO  = 2'd1;
    localparam logic [1:0] KIND_EVENT = 2'd2;
    localparam logic [1:0] KIND_EOF   = 2'd3;

    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_BS = 8'd8;
    localparam logic [7:0] CH_SP = 8'd32;

    localparam logic [7:0] EVT_INTR = 8'd0;
    localparam logic [7:0] EVT_QUIT = 8'd1;
    localparam logic [7:0] EVT_SUSP = 8'd2;

    typedef logic [2:0] vsel_t;

    localparam vsel_t VSEL_BYTE  = 3'd0;
    localparam vsel_t VSEL_CR    = 3'd1;
    localparam vsel_t VSEL_LF    = 3'd2;
    localparam vsel_t VSEL_BS    = 3'd3;
    localparam vsel_t VSEL_SP    = 3'd4;
    localparam vsel_t VSEL_EVENT = 3'd5;
    localparam vsel_t VSEL_ZERO  = 3'd6;
    localparam vsel_t VSEL_RD    = 3'd7;

    typedef struct packed {
        logic       capture;
        logic       len_dec;
        logic       len_clr;
        logic       store_wr;
        logic       idx_clr;
        logic       idx_inc;
        logic       cm_read;
        logic       out_load;
        logic       out_last;
        logic [1:0] out_kind;
        vsel_t      out_sel;
    } cmd_t;

    typedef struct packed {
        logic ignore;
        logic is_signal;
        logic handler;
        logic canon;
        logic is_erase;
        logic is_kill;
        logic is_eof;
        logic len_zero;
        logic can_store;
        logic is_lf;
        logic echo_on;
        logic crlf_echo;
        logic erase_echo_en;
        logic kill_echo_en;
        logic cm_more;
        logic out_ready;
    } sts_t;

endpackage

`default_nettype wire

FILE: rtl/ttyld_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ttyld_dp
    import ttyld_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [7:0]            rx_byte,
    input  wire logic                  out_stall,
    output logic                       out_valid,
    output logic [1:0]                 out_kind,
    output logic [7:0]                 out_value,
    output logic                       out_last,
    input  wire cmd_t                  cmd,
    output sts_t                       sts
);

    localparam int IDX_W = $clog2(LINE_DEPTH);
    localparam int LEN_W = $clog2(LINE_DEPTH + 1);

    logic [2:0]       input_map_reg;
    logic [5:0]       local_mode_reg;
    logic             echo_crlf_reg;
    logic [23:0]      signal_chars_reg;
    logic [23:0]      edit_chars_reg;
    logic             handler_reg;

    logic [7:0]       byte_reg;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [7:0]       rd_data_reg;
    logic             out_valid_reg;
    logic [1:0]       out_kind_reg;
    logic [7:0]       out_value_reg;
    logic             out_last_reg;

    logic [7:0]       line_mem [0:LINE_DEPTH-1];

    logic [7:0]       mapped;
    logic             ignore_cr;
    logic             is_lf;
    logic [7:0]       evt_code;
    logic [7:0]       sel_value;
    logic [LEN_W-1:0] limit;

    always_comb
    begin
        mapped    = byte_reg;
        ignore_cr = 1'b0;
        if (byte_reg == CH_CR)
        begin
            ignore_cr = input_map_reg[0];
            if (input_map_reg[1])
            begin
                mapped = CH_LF;
            end
        end
        else if (byte_reg == CH_LF && input_map_reg[2])
        begin
            mapped = CH_CR;
        end
    end

    assign is_lf = (mapped == CH_LF);
    assign limit = is_lf ? LEN_W'(LINE_DEPTH) : LEN_W'(LINE_DEPTH - 1);

    always_comb
    begin
        if (mapped == signal_chars_reg[7:0])
        begin
            evt_code = EVT_INTR;
        end
        else if (mapped == signal_chars_reg[15:8])
        begin
            evt_code = EVT_QUIT;
        end
        else
        begin
            evt_code = EVT_SUSP;
        end
    end

    always_comb
    begin
        sts.ignore        = ignore_cr;
        sts.is_signal     = local_mode_reg[0] && (mapped == signal_chars_reg[7:0] ||
                            mapped == signal_chars_reg[15:8] || mapped == signal_chars_reg[23:16]);
        sts.handler       = handler_reg;
        sts.canon         = local_mode_reg[1];
        sts.is_erase      = (mapped == edit_chars_reg[7:0]);
        sts.is_kill       = (mapped == edit_chars_reg[15:8]);
        sts.is_eof        = (mapped == edit_chars_reg[23:16]);
        sts.len_zero      = (len_reg == '0);
        sts.can_store     = (len_reg < limit);
        sts.is_lf         = is_lf;
        sts.echo_on       = local_mode_reg[2] || (is_lf && local_mode_reg[5]);
        sts.crlf_echo     = is_lf && echo_crlf_reg;
        sts.erase_echo_en = local_mode_reg[3];
        sts.kill_echo_en  = local_mode_reg[4];
        sts.cm_more       = (LEN_W'(idx_reg) + LEN_W'(1)) < len_reg;
        sts.out_ready     = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        len_next = len_reg;
        if (cmd.len_clr)
        begin
            len_next = '0;
        end
        else if (cmd.len_dec)
        begin
            len_next = len_reg - LEN_W'(1);
        end
        else if (cmd.store_wr)
        begin
            len_next = len_reg + LEN_W'(1);
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_comb
    begin
        case (cmd.out_sel)
            VSEL_BYTE:  sel_value = mapped;
            VSEL_CR:    sel_value = CH_CR;
            VSEL_LF:    sel_value = CH_LF;
            VSEL_BS:    sel_value = CH_BS;
            VSEL_SP:    sel_value = CH_SP;
            VSEL_EVENT: sel_value = evt_code;
            VSEL_RD:    sel_value = rd_data_reg;
            default:    sel_value = 8'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_map_reg    <= RST_INPUT_MAP;
            local_mode_reg   <= RST_LOCAL_MODE;
            echo_crlf_reg    <= RST_ECHO_CRLF;
            signal_chars_reg <= RST_SIGNAL_CHARS;
            edit_chars_reg   <= RST_EDIT_CHARS;
            handler_reg      <= RST_HANDLER;
            len_reg          <= '0;
            idx_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_INPUT_MAP:    input_map_reg    <= cfg_wdata[2:0];
                    CFG_LOCAL_MODE:   local_mode_reg   <= cfg_wdata[5:0];
                    CFG_ECHO_CRLF:    echo_crlf_reg    <= cfg_wdata[0];
                    CFG_SIGNAL_CHARS: signal_chars_reg <= cfg_wdata[23:0];
                    CFG_EDIT_CHARS:   edit_chars_reg   <= cfg_wdata[23:0];
                    CFG_HANDLER:      handler_reg      <= cfg_wdata[0];
                    default:          ;
                endcase
            end
            len_reg <= len_next;
            idx_reg <= idx_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            byte_reg <= rx_byte;
        end
        if (cmd.out_load)
        begin
            out_kind_reg  <= cmd.out_kind;
            out_value_reg <= sel_value;
            out_last_reg  <= cmd.out_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_wr)
        begin
            line_mem[len_reg[IDX_W-1:0]] <= mapped;
        end
        if (cmd.cm_read)
        begin
            rd_data_reg <= line_mem[idx_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(LINE_DEPTH))
        else $error("line length beyond depth");

    a_store_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_wr |-> len_reg < LEN_W'(LINE_DEPTH))
        else $error("store write into a full line");

    a_read_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cm_read |-> LEN_W'(idx_reg) < len_reg)
        else $error("commit read beyond line length");

endmodule

`default_nettype wire

FILE: rtl/ttyld_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ttyld_ctrl
    import ttyld_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_RAW    = 4'd2;
    localparam logic [3:0] ST_ECR    = 4'd3;
    localparam logic [3:0] ST_EBYTE  = 4'd4;
    localparam logic [3:0] ST_BS1    = 4'd5;
    localparam logic [3:0] ST_SP     = 4'd6;
    localparam logic [3:0] ST_BS2    = 4'd7;
    localparam logic [3:0] ST_KILL   = 4'd8;
    localparam logic [3:0] ST_EVENT  = 4'd9;
    localparam logic [3:0] ST_EOF    = 4'd10;
    localparam logic [3:0] ST_CM_RD  = 4'd11;
    localparam logic [3:0] ST_CM_OUT = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       emit;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        emit         = 1'b0;
        cmd.out_sel  = VSEL_ZERO;
        cmd.out_kind = KIND_ECHO;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.idx_clr = 1'b1;
                if (sts.ignore)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.is_signal)
                begin
                    state_next = sts.handler ? ST_EVENT : ST_IDLE;
                end
                else if (sts.canon)
                begin
                    if (sts.is_erase)
                    begin
                        cmd.len_dec = !sts.len_zero;
                        state_next  = (!sts.len_zero && sts.erase_echo_en) ? ST_BS1 : ST_IDLE;
                    end
                    else if (sts.is_kill)
                    begin
                        cmd.len_clr = 1'b1;
                        state_next  = sts.kill_echo_en ? ST_KILL : ST_IDLE;
                    end
                    else if (sts.is_eof)
                    begin
                        state_next = sts.len_zero ? ST_EOF : ST_CM_RD;
                    end
                    else if (sts.can_store)
                    begin
                        cmd.store_wr = 1'b1;
                        if (sts.echo_on)
                        begin
                            state_next = sts.crlf_echo ? ST_ECR : ST_EBYTE;
                        end
                        else
                        begin
                            state_next = sts.is_lf ? ST_CM_RD : ST_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_RAW;
                end
            end
            ST_RAW:
            begin
                emit         = 1'b1;
                cmd.out_kind = KIND_DATA;
                cmd.out_sel  = VSEL_BYTE;
                cmd.out_last = !sts.echo_on;
                if (sts.out_ready)
                begin
                    if (sts.echo_on)
                    begin
                        state_next = sts.crlf_echo ? ST_ECR : ST_EBYTE;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ECR:
            begin
                emit        = 1'b1;
                cmd.out_sel = VSEL_CR;
                if (sts.out_ready)
                begin
                    state_next = ST_EBYTE;
                end
            end
            ST_EBYTE:
            begin
                emit         = 1'b1;
                cmd.out_sel  = VSEL_BYTE;
                cmd.out_last = !(sts.canon && sts.is_lf);
                if (sts.out_ready)
                begin
                    state_next = (sts.canon && sts.is_lf) ? ST_CM_RD : ST_IDLE;
                end
            end
            ST_BS1:
            begin
                emit        = 1'b1;
                cmd.out_sel = VSEL_BS;
                if (sts.out_ready)
                begin
                    state_next = ST_SP;
                end
            end
            ST_SP:
            begin
                emit        = 1'b1;
                cmd.out_sel = VSEL_SP;
                if (sts.out_ready)
                begin
                    state_next = ST_BS2;
                end
            end
            ST_BS2:
            begin
                emit         = 1'b1;
                cmd.out_sel  = VSEL_BS;
                cmd.out_last = 1'b1;
                if (sts.out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_KILL:
            begin
                emit         = 1'b1;
                cmd.out_sel  = VSEL_LF;
                cmd.out_last = 1'b1;
                if (sts.out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EVENT:
            begin
                emit         = 1'b1;
                cmd.out_kind = KIND_EVENT;
                cmd.out_sel  = VSEL_EVENT;
                cmd.out_last = 1'b1;
                if (sts.out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EOF:
            begin
                emit         = 1'b1;
                cmd.out_kind = KIND_EOF;
                cmd.out_sel  = VSEL_ZERO;
                cmd.out_last = 1'b1;
                if (sts.out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CM_RD:
            begin
                cmd.cm_read = 1'b1;
                state_next  = ST_CM_OUT;
            end
            ST_CM_OUT:
            begin
                emit         = 1'b1;
                cmd.out_kind = KIND_DATA;
                cmd.out_sel  = VSEL_RD;
                cmd.out_last = !sts.cm_more;
                if (sts.out_ready)
                begin
                    if (sts.cm_more)
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_CM_RD;
                    end
                    else
                    begin
                        cmd.len_clr = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        cmd.out_load = emit && sts.out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_DECODE))
        else $error("accepted transaction not decoded");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && cmd.out_last) |=> (state_reg == ST_IDLE))
        else $error("results continue after last");

    a_decode_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECODE) |=> (state_reg != ST_DECODE))
        else $error("decode held more than one cycle");

endmodule

`default_nettype wire

FILE: rtl/tty_input_line_discipline.sv
// Receive-side terminal line discipline. One received byte is taken per transaction
// on the input channel (in_valid/in_stall); the results it causes leave one per
// transaction on the output channel, with out_last marking the final one (a byte
// may cause none). A byte is captured in the idle state and decoded in the decode
// state; each result then enters the output register while the output is not
// stalled. A committed line reads each stored byte via the line store's registered
// read port, then presents it. The next byte is taken once the last result of the
// previous one sits in the output register. Configuration registers are written
// through cfg_wr_en, cfg_index and cfg_wdata; the user must do so only while no
// byte is in progress (not enforced); the line store needs no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none

module tty_input_line_discipline
    import ttyld_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            rx_byte,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [1:0]                 out_kind,
    output logic [7:0]                 out_value,
    output logic                       out_last
);

    cmd_t cmd;
    sts_t sts;

    ttyld_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    ttyld_dp #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .rx_byte   (rx_byte),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_kind  (out_kind),
        .out_value (out_value),
        .out_last  (out_last),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ttyld_pkg::*;

    localparam int LINE_DEPTH  = LINE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 16;

    localparam logic [7:0] INTR_CH  = RST_SIGNAL_CHARS[7:0];
    localparam logic [7:0] QUIT_CH  = RST_SIGNAL_CHARS[15:8];
    localparam logic [7:0] SUSP_CH  = RST_SIGNAL_CHARS[23:16];
    localparam logic [7:0] ERASE_CH = RST_EDIT_CHARS[7:0];
    localparam logic [7:0] KILL_CH  = RST_EDIT_CHARS[15:8];
    localparam logic [7:0] EOF_CH   = RST_EDIT_CHARS[23:16];

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       last;
    } tty_result_t;

    class tty_scoreboard;
        logic [2:0]  map_mode;
        logic [5:0]  lmode;
        logic        crlf;
        logic [23:0] sig_chars;
        logic [23:0] edit_chars;
        logic        handler;
        logic [7:0]  line_buf [LINE_DEPTH];
        int          line_len;
        tty_result_t expected [$];
        int          n_new;
        int          n_checked;
        int          errors;

        function new();
            map_mode   = RST_INPUT_MAP;
            lmode      = RST_LOCAL_MODE;
            crlf       = RST_ECHO_CRLF;
            sig_chars  = RST_SIGNAL_CHARS;
            edit_chars = RST_EDIT_CHARS;
            handler    = RST_HANDLER;
            line_len   = 0;
            n_new      = 0;
            n_checked  = 0;
            errors     = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_INPUT_MAP:    map_mode   = value[2:0];
                CFG_LOCAL_MODE:   lmode      = value[5:0];
                CFG_ECHO_CRLF:    crlf       = value[0];
                CFG_SIGNAL_CHARS: sig_chars  = value;
                CFG_EDIT_CHARS:   edit_chars = value;
                CFG_HANDLER:      handler    = value[0];
                default: ;
            endcase
        endfunction

        function void push_result(logic [1:0] kind, logic [7:0] value);
            tty_result_t r;
            r.kind  = kind;
            r.value = value;
            r.last  = 1'b0;
            expected.insert(expected.size(), r);
            n_new++;
        endfunction

        function void echo_stored(logic [7:0] b);
            if (lmode[2] || (b == CH_LF && lmode[5]))
            begin
                if (b == CH_LF && crlf)
                    push_result(KIND_ECHO, CH_CR);
                push_result(KIND_ECHO, b);
            end
        endfunction

        function void commit_line();
            for (int i = 0; i < line_len; i++)
                push_result(KIND_DATA, line_buf[i]);
            line_len = 0;
        endfunction

        function void note_input(logic [7:0] rx);
            logic [7:0] b;
            b = rx;
            n_new = 0;
            if (b == CH_CR && map_mode[0])
                return;
            if (b == CH_CR && map_mode[1])
                b = CH_LF;
            else if (b == CH_LF && map_mode[2])
                b = CH_CR;

            if (lmode[0] && (b == sig_chars[7:0] || b == sig_chars[15:8]
                             || b == sig_chars[23:16]))
            begin
                if (handler)
                    push_result(KIND_EVENT, (b == sig_chars[7:0]) ? EVT_INTR :
                                            (b == sig_chars[15:8]) ? EVT_QUIT : EVT_SUSP);
            end
            else if (lmode[1])
            begin
                if (b == edit_chars[7:0])
                begin
                    if (line_len != 0)
                    begin
                        line_len--;
                        if (lmode[3])
                        begin
                            push_result(KIND_ECHO, CH_BS);
                            push_result(KIND_ECHO, CH_SP);
                            push_result(KIND_ECHO, CH_BS);
                        end
                    end
                end
                else if (b == edit_chars[15:8])
                begin
                    line_len = 0;
                    if (lmode[4])
                        push_result(KIND_ECHO, CH_LF);
                end
                else if (b == edit_chars[23:16])
                begin
                    if (line_len == 0)
                        push_result(KIND_EOF, 8'h00);
                    else
                        commit_line();
                end
                else if (line_len < ((b == CH_LF) ? LINE_DEPTH : LINE_DEPTH - 1))
                begin
                    line_buf[line_len] = b;
                    line_len++;
                    echo_stored(b);
                    if (b == CH_LF)
                        commit_line();
                end
            end
            else
            begin
                push_result(KIND_DATA, b);
                echo_stored(b);
            end

            if (n_new > 0)
                expected[expected.size() - 1].last = 1'b1;
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_result(logic [1:0] kind, logic [7:0] value, logic last);
            tty_result_t want;
            n_checked++;
            if (expected.size() == 0)
            begin
                report_mismatch($sformatf(
                    "result %0d kind %0d value 0x%02h last %0b, none expected",
                    n_checked, kind, value, last));
                return;
            end
            want = expected.pop_front();
            if (kind !== want.kind || value !== want.value || last !== want.last)
                report_mismatch($sformatf(
                    "result %0d got kind %0d value 0x%02h last %0b, %s",
                    n_checked, kind, value, last,
                    $sformatf("want kind %0d value 0x%02h last %0b",
                              want.kind, want.value, want.last)));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [7:0]            rx_byte   = 8'h00;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [1:0]            out_kind;
    logic [7:0]            out_value;
    logic                  out_last;

    tty_scoreboard sb;
    bit            quiet = 1'b0;
    int            cycles = 0;

    tty_input_line_discipline #(.LINE_DEPTH(LINE_DEPTH)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_kind  (out_kind),
        .out_value (out_value),
        .out_last  (out_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        sb.set_register(idx, value);
    endtask

    task automatic apply_config(input logic [2:0] map, input logic [5:0] lm, input logic crlf,
                                input logic [23:0] sig, input logic [23:0] edit,
                                input logic handler);
        write_reg(CFG_INPUT_MAP, {21'b0, map});
        write_reg(CFG_LOCAL_MODE, {18'b0, lm});
        write_reg(CFG_ECHO_CRLF, {23'b0, crlf});
        write_reg(CFG_SIGNAL_CHARS, sig);
        write_reg(CFG_EDIT_CHARS, edit);
        write_reg(CFG_HANDLER, {23'b0, handler});
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // hold the byte until the block takes it
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 5);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(b);
    endtask

    task automatic send_list(input logic [7:0] list [$]);
        foreach (list[i])
            send_byte(list[i]);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    function automatic logic [7:0] special_byte();
        case ($urandom_range(0, 7))
            0: return sb.sig_chars[7:0];
            1: return sb.sig_chars[15:8];
            2: return sb.sig_chars[23:16];
            3: return sb.edit_chars[7:0];
            4: return sb.edit_chars[15:8];
            5: return sb.edit_chars[23:16];
            6: return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [23:0] pick_chars(input logic [23:0] base);
        logic [23:0] v;
        v = base;
        for (int k = 0; k < 3; k++)
            if ($urandom_range(0, 1) == 0)
                v[8*k +: 8] = 8'($urandom_range(0, 255));
        return v;
    endfunction

    // send mostly whole lines with random content, the rest as loose bytes
    task automatic random_phase(input int n_items);
        int  sent;
        int  len;
        bit  long_line;
        logic [7:0] b;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                long_line = ($urandom_range(0, 5) == 0);
                len = long_line ? $urandom_range(28, 36) : $urandom_range(0, 8);
                for (int i = 0; i < len; i++)
                begin
                    if (!long_line && $urandom_range(0, 99) < 15)
                        b = special_byte();
                    else
                        b = 8'($urandom_range(32, 126));
                    send_byte(b);
                end
                case ($urandom_range(0, 3))
                    0: b = CH_LF;
                    1: b = CH_CR;
                    2: b = sb.edit_chars[23:16];
                    default: b = sb.edit_chars[15:8];
                endcase
                send_byte(b);
                sent += len + 1;
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                    b = 8'($urandom_range(0, 255));
                else
                    b = special_byte();
                send_byte(b);
                sent++;
            end
        end
    endtask

    initial
    begin : result_sink
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                sb.check_result(out_kind, out_value, out_last);
                hold = quiet ? 0 : $urandom_range(0, 5);
            end
            @(negedge clk);
            out_stall <= (hold > 0);
            if (hold > 0)
                hold--;
        end
    end

    initial
    begin : watchdog
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("** tty_input_line_discipline: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        logic [5:0] lm;
        sb = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: echo, edits, commits, swallowed signals
        send_list('{8'h41, ERASE_CH, ERASE_CH, 8'h00, 8'hFF, CH_CR, EOF_CH, 8'h78, EOF_CH,
                    8'h79, KILL_CH, INTR_CH, QUIT_CH, SUSP_CH, CH_LF});
        drain();

        // ignored CR, LF to CR, shared signal and edit bytes, events
        apply_config(3'd7, 6'b111111, 1'b0, {QUIT_CH, QUIT_CH, INTR_CH},
                     {KILL_CH, KILL_CH, ERASE_CH}, 1'b1);
        send_list('{CH_CR, CH_LF, ERASE_CH, ERASE_CH, INTR_CH, QUIT_CH, 8'h41, KILL_CH});
        drain();

        // raw mode with newline echo only
        apply_config(3'd0, 6'b100001, 1'b1, RST_SIGNAL_CHARS, RST_EDIT_CHARS, 1'b1);
        send_list('{SUSP_CH, CH_LF, 8'h41, CH_CR});
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            quiet = (phase % 3 == 2);
            if (phase == 0)
                apply_config(3'd7, 6'd63, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
            else if (phase == 1)
                apply_config(3'd0, 6'd0, 1'b0, 24'h000000, 24'h000000, 1'b0);
            else
            begin
                lm = 6'($urandom_range(0, 63));
                if ($urandom_range(0, 3) != 0)
                    lm[1] = 1'b1;
                apply_config(3'($urandom_range(0, 7)), lm, 1'($urandom_range(0, 1)),
                             pick_chars(RST_SIGNAL_CHARS), pick_chars(RST_EDIT_CHARS),
                             1'($urandom_range(0, 1)));
            end
            random_phase(34);
            drain();
        end

        if (sb.expected.size() != 0)
            sb.report_mismatch($sformatf("%0d expected results never arrived",
                                         sb.expected.size()));
        if (sb.errors == 0)
            $display("** tty_input_line_discipline: PASSED **");
        else
            $display("** tty_input_line_discipline: FAILED **");
        $finish;
    end

endmodule
